/* sv/agf_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the ADC glitch filter.
package agf_pkg;

   localparam int SAMPLE_W           = 12;
   localparam int CHAN_W             = 3;
   localparam int DEF_CHANNELS       = 8;
   localparam int DEF_HISTORY_DEPTH  = 8;

   localparam int CSR_ADDR_W         = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_WORD_W         = CSR_ADDR_W - 2;

   localparam logic [CSR_WORD_W-1:0] REG_HYST   = CSR_WORD_W'(0);
   localparam logic [SAMPLE_W-1:0]   HYST_RESET = SAMPLE_W'(64);

   localparam int ALU_OP_W = 2;
   localparam logic [ALU_OP_W-1:0] ALU_DIFF  = 2'd0;
   localparam logic [ALU_OP_W-1:0] ALU_ADD   = 2'd1;
   localparam logic [ALU_OP_W-1:0] ALU_SCALE = 2'd2;

   typedef struct packed {
      logic [ALU_OP_W-1:0] op;
      logic [SAMPLE_W-1:0] hyst;
   } alu_ctl_type;

endpackage

/* sv/agf_req_if.sv */
`timescale 1ns / 1ps
// Input channel: channel number and raw conversion value.
interface agf_req_if;
   import agf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   channel;
   logic [SAMPLE_W-1:0] sample_value;

   modport source (output valid, output channel, output sample_value, input ready);
   modport sink   (input valid, input channel, input sample_value, output ready);
endinterface

/* sv/agf_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel: filtered conversion value.
interface agf_rsp_if;
   import agf_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] filtered_value;

   modport source (output valid, output filtered_value, input ready);
   modport sink   (input valid, input filtered_value, output ready);
endinterface

/* sv/agf_alu.sv */
`timescale 1ns / 1ps
// Shared arithmetic unit: one adder for hysteresis test and ring sum, reciprocal scaler.
module agf_alu #(
   parameter int HISTORY_DEPTH = agf_pkg::DEF_HISTORY_DEPTH,
   localparam int SUM_W = agf_pkg::SAMPLE_W + $clog2(HISTORY_DEPTH)
) (
   input  agf_pkg::alu_ctl_type         ctl,
   input  logic [SUM_W-1:0]             opa,
   input  logic [agf_pkg::SAMPLE_W-1:0] opb,
   output logic [SUM_W-1:0]             result,
   output logic                         hit,
   output logic [agf_pkg::SAMPLE_W-1:0] quot
);
   import agf_pkg::*;

   localparam int AW    = SUM_W + 1;
   localparam int SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
   localparam int REC_W = SUM_W + 1;
   localparam int PW    = SUM_W + REC_W;
   // ceil(2^SHIFT / depth): exact floor division for every sum below 2^SUM_W
   localparam logic [REC_W-1:0] RECIP =
      REC_W'(((64'd1 << SHIFT) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

   logic          sub;
   logic [AW-1:0] x;
   logic [AW-1:0] y;
   logic [AW-1:0] s;
   logic [AW-1:0] mag;
   logic [PW-1:0] prod;

   assign sub    = (ctl.op == ALU_DIFF);
   assign x      = {1'b0, opa};
   assign y      = {(AW-SAMPLE_W)'(0), opb};
   assign s      = x + (sub ? ~y : y) + AW'(sub);
   assign mag    = s[AW-1] ? (~s + AW'(1)) : s;
   assign hit    = sub && (mag <= AW'(ctl.hyst));
   assign result = s[SUM_W-1:0];

   assign prod = PW'(opa) * PW'(RECIP);
   assign quot = (ctl.op == ALU_SCALE) ? prod[SHIFT +: SAMPLE_W] : '0;

endmodule

/* sv/agf_hist_mem.sv */
`timescale 1ns / 1ps
// Per-channel sample ring store with registered read and per-entry valid bits.
module agf_hist_mem #(
   parameter int CHANNELS      = agf_pkg::DEF_CHANNELS,
   parameter int HISTORY_DEPTH = agf_pkg::DEF_HISTORY_DEPTH,
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
   localparam int IDX_W = $clog2(HISTORY_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         we,
   input  logic [CH_W-1:0]              wch,
   input  logic [IDX_W-1:0]             widx,
   input  logic [agf_pkg::SAMPLE_W-1:0] wdata,
   input  logic [CH_W-1:0]              rch,
   input  logic [IDX_W-1:0]             ridx,
   output logic [agf_pkg::SAMPLE_W-1:0] rdata
);
   import agf_pkg::*;

   logic [SAMPLE_W-1:0] store_ff [CHANNELS][HISTORY_DEPTH];
   logic                vld_ff   [CHANNELS][HISTORY_DEPTH];
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                rvld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wch][widx] <= wdata;
      end
      rdata_ff <= store_ff[rch][ridx];
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               vld_ff[c][i] <= 1'b0;
            end
         end
         rvld_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[wch][widx] <= 1'b1;
         end
         rvld_ff <= vld_ff[rch][ridx];
      end
   end

   assign rdata = rvld_ff ? rdata_ff : '0;

endmodule

/* sv/adc_glitch_filter_top.sv */
`timescale 1ns / 1ps
// ADC glitch filter top level: sequencer, per-channel state, rings and register port.
//
//  port group  | direction | content
//  ------------+-----------+------------------------------------------------
//  req_bus     | in        | channel, sample_value (valid/ready)
//  rsp_bus     | out       | filtered_value (valid/ready)
//  psel..      | in/out    | APB register port, hysteresis at byte 0
//
//  One transaction at a time. Accept, then a setup step, then the search
//  walks the accepted ring through the shared adder, one entry per cycle
//  behind the registered ring read; a match ends the search. Without a match
//  the block sums the ring (or copies the suspect ring while summing it),
//  then divides by HISTORY_DEPTH. The ring memory read port sets the pace.
//  A finished result waits in the output register while the next transaction
//  is accepted; the sequencer stalls only if that register is still full.
//  Reset is synchronous and clears all rings through per-entry valid bits,
//  so the block is ready straight out of reset.
module adc_glitch_filter_top #(
   parameter int CHANNELS      = agf_pkg::DEF_CHANNELS,
   parameter int HISTORY_DEPTH = agf_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   agf_req_if.sink                        req_bus,
   agf_rsp_if.source                      rsp_bus,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [agf_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [agf_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [agf_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import agf_pkg::*;

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = SAMPLE_W + $clog2(HISTORY_DEPTH);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0] LAST_TRY = CNT_W'(HISTORY_DEPTH - 1);

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [ST_W-1:0] ST_START  = 3'd1;
   localparam logic [ST_W-1:0] ST_SEARCH = 3'd2;
   localparam logic [ST_W-1:0] ST_SUM    = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV    = 3'd4;
   localparam logic [ST_W-1:0] ST_DONE   = 3'd5;

   // control state
   logic [ST_W-1:0]     state_ff, state_in;
   logic                pend_ff, pend_in;
   logic                copy_ff, copy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] hyst_ff, hyst_in;
   logic [IDX_W-1:0]    rp_ff  [CHANNELS];
   logic [CNT_W-1:0]    cnt_ff [CHANNELS];

   // payload
   logic [CHAN_W-1:0]   ch_ff, ch_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [IDX_W-1:0]    issue_ff, issue_in;
   logic [CNT_W-1:0]    issued_ff, issued_in;
   logic [CNT_W-1:0]    tries_ff, tries_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] res_ff, res_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   // per-channel state updates
   logic                rp_we;
   logic [IDX_W-1:0]    rp_wdata;
   logic                cnt_we;
   logic [CNT_W-1:0]    cnt_wdata;

   // ring ports
   logic                acc_we;
   logic [IDX_W-1:0]    acc_widx;
   logic [SAMPLE_W-1:0] acc_wdata;
   logic [SAMPLE_W-1:0] acc_rdata;
   logic                sus_we;
   logic [SAMPLE_W-1:0] sus_rdata;

   // shared unit
   alu_ctl_type         alu_ctl;
   logic [SUM_W-1:0]    alu_opa;
   logic [SAMPLE_W-1:0] alu_opb;
   logic [SUM_W-1:0]    alu_result;
   logic                alu_hit;
   logic [SAMPLE_W-1:0] alu_quot;

   logic [CH_W-1:0]     chi;
   logic                ch_ok;
   logic                issue_go;
   logic                out_free;
   logic                csr_wr;
   logic [CSR_WORD_W-1:0] csr_word;

   assign chi      = ch_ff[CH_W-1:0];
   assign ch_ok    = ((CHAN_W+1)'(ch_ff) < (CHAN_W+1)'(CHANNELS));
   assign issue_go = (issued_ff != DEPTH_C);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // ------------------------------------------------------------------
   // Register port: hysteresis only; writes elsewhere are dropped.
   // ------------------------------------------------------------------
   assign pready   = 1'b1;
   assign csr_word = paddr[CSR_ADDR_W-1:2];
   assign csr_wr   = psel && penable && pwrite && (csr_word == REG_HYST);
   assign hyst_in  = csr_wr ? pwdata[SAMPLE_W-1:0] : hyst_ff;
   assign prdata   = (csr_word == REG_HYST) ? CSR_DATA_W'(hyst_ff) : '0;

   // ------------------------------------------------------------------
   // Channel handshakes
   // ------------------------------------------------------------------
   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = rsp_data_ff;

   // ------------------------------------------------------------------
   // Rings: accepted and suspect history share the read index
   // ------------------------------------------------------------------
   agf_hist_mem #(
      .CHANNELS      (CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_acc_mem (
      .clock (clock),
      .reset (reset),
      .we    (acc_we),
      .wch   (chi),
      .widx  (acc_widx),
      .wdata (acc_wdata),
      .rch   (chi),
      .ridx  (issue_ff),
      .rdata (acc_rdata)
   );

   agf_hist_mem #(
      .CHANNELS      (CHANNELS),
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_sus_mem (
      .clock (clock),
      .reset (reset),
      .we    (sus_we),
      .wch   (chi),
      .widx  (cnt_ff[chi][IDX_W-1:0]),
      .wdata (sample_ff),
      .rch   (chi),
      .ridx  (issue_ff),
      .rdata (sus_rdata)
   );

   agf_alu #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .result (alu_result),
      .hit    (alu_hit),
      .quot   (alu_quot)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      copy_in      = copy_ff;
      ch_in        = ch_ff;
      sample_in    = sample_ff;
      pos_in       = pos_ff;
      issue_in     = issue_ff;
      issued_in    = issued_ff;
      tries_in     = tries_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      rp_we        = 1'b0;
      rp_wdata     = pos_ff;
      cnt_we       = 1'b0;
      cnt_wdata    = '0;
      acc_we       = 1'b0;
      acc_widx     = pos_ff;
      acc_wdata    = sample_ff;
      sus_we       = 1'b0;
      alu_ctl.op   = ALU_DIFF;
      alu_ctl.hyst = hyst_ff;
      alu_opa      = SUM_W'(sample_ff);
      alu_opb      = acc_rdata;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               ch_in     = req_bus.channel;
               sample_in = req_bus.sample_value;
               state_in  = ST_START;
            end
         end

         ST_START: begin
            if (!ch_ok) begin
               // unknown channel: pass the sample through untouched
               res_in   = sample_ff;
               state_in = ST_DONE;
            end else begin
               pos_in    = rp_ff[chi];
               issue_in  = rp_ff[chi];
               issued_in = '0;
               tries_in  = '0;
               pend_in   = 1'b0;
               state_in  = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // issue one read per cycle, test the one that came back
            if (issue_go) begin
               issue_in  = (issue_ff == LAST_IDX) ? '0 : issue_ff + IDX_W'(1);
               issued_in = issued_ff + CNT_W'(1);
            end
            pend_in = issue_go;
            if (pend_ff) begin
               if (alu_hit) begin
                  // step back one slot and store the sample there
                  rp_we     = 1'b1;
                  rp_wdata  = (pos_ff == '0) ? LAST_IDX : pos_ff - IDX_W'(1);
                  acc_we    = 1'b1;
                  acc_widx  = rp_wdata;
                  cnt_we    = 1'b1;
                  cnt_wdata = '0;
                  res_in    = sample_ff;
                  state_in  = ST_DONE;
               end else begin
                  pos_in   = (pos_ff == LAST_IDX) ? '0 : pos_ff + IDX_W'(1);
                  tries_in = tries_ff + CNT_W'(1);
                  if (tries_ff == LAST_TRY) begin
                     // no match; read position is back at its start
                     cnt_we = 1'b1;
                     if (cnt_ff[chi] == DEPTH_C) begin
                        copy_in   = 1'b1;
                        cnt_wdata = '0;
                     end else begin
                        copy_in   = 1'b0;
                        sus_we    = 1'b1;
                        cnt_wdata = cnt_ff[chi] + CNT_W'(1);
                     end
                     issue_in  = '0;
                     issued_in = '0;
                     pos_in    = '0;
                     tries_in  = '0;
                     pend_in   = 1'b0;
                     sum_in    = '0;
                     state_in  = ST_SUM;
                  end
               end
            end
         end

         ST_SUM: begin
            // sum the ring; on overflow of suspects copy them over while summing
            alu_ctl.op = ALU_ADD;
            alu_opa    = sum_ff;
            alu_opb    = copy_ff ? sus_rdata : acc_rdata;
            if (issue_go) begin
               issue_in  = (issue_ff == LAST_IDX) ? '0 : issue_ff + IDX_W'(1);
               issued_in = issued_ff + CNT_W'(1);
            end
            pend_in = issue_go;
            if (pend_ff) begin
               sum_in    = alu_result;
               acc_we    = copy_ff;
               acc_widx  = pos_ff;
               acc_wdata = sus_rdata;
               pos_in    = (pos_ff == LAST_IDX) ? '0 : pos_ff + IDX_W'(1);
               tries_in  = tries_ff + CNT_W'(1);
               if (tries_ff == LAST_TRY) begin
                  state_in = ST_DIV;
               end
            end
         end

         ST_DIV: begin
            alu_ctl.op = ALU_SCALE;
            alu_opa    = sum_ff;
            res_in     = alu_quot;
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         copy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hyst_ff      <= HYST_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            rp_ff[c]  <= '0;
            cnt_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         copy_ff      <= copy_in;
         rsp_valid_ff <= rsp_valid_in;
         hyst_ff      <= hyst_in;
         if (rp_we) begin
            rp_ff[chi] <= rp_wdata;
         end
         if (cnt_we) begin
            cnt_ff[chi] <= cnt_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      sample_ff   <= sample_in;
      pos_ff      <= pos_in;
      issue_ff    <= issue_in;
      issued_ff   <= issued_in;
      tries_ff    <= tries_in;
      sum_ff      <= sum_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* sv/agf_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the ADC glitch filter, bound to the top level.
module agf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [agf_pkg::SAMPLE_W-1:0]   rsp_data,
   input logic                           psel,
   input logic                           pwrite,
   input logic [agf_pkg::CSR_ADDR_W-1:0] paddr,
   input logic [agf_pkg::CSR_DATA_W-1:0] prdata
);
   import agf_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in flight");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while the block sat idle");

   a_hyst_readback: assert property (@(posedge clock) disable iff (reset)
      psel && !pwrite && (paddr[CSR_ADDR_W-1:2] == REG_HYST)
         |-> (prdata[CSR_DATA_W-1:SAMPLE_W] == '0))
      else $error("hysteresis readback wider than its field");

endmodule

bind adc_glitch_filter_top agf_checker u_agf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_data  (rsp_bus.filtered_value),
   .psel      (psel),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .prdata    (prdata)
);
